// File: hdl/rmq_pkg.sv
// ----------------------------------------------------------------------------
// rmq_pkg
// Shared constants for the block range minimum / maximum query engine.
// ----------------------------------------------------------------------------
package rmq_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned IDX_W  = 10;
  localparam int unsigned OP_W   = 2;

  localparam logic signed [DATA_W-1:0] INT_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] INT_MIN = 32'sh8000_0000;

  localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  // Read port result tag: which store the registered read data came from.
  typedef enum logic {
    SRC_ELEMENT = 1'b0,
    SRC_SUMMARY = 1'b1
  } rd_src_e;

endpackage

// File: hdl/rmq_ram.sv
// ----------------------------------------------------------------------------
// rmq_ram
// Simple dual-port synchronous RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module rmq_ram #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned WIDTH = 32,
  parameter int unsigned AW    = 5
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [WIDTH-1:0] wr_data_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_q <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: hdl/block_range_min_max_query.sv
// ----------------------------------------------------------------------------
// block_range_min_max_query
// Range minimum and maximum over a stored signed array with block summaries.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one item: op_i selects a
//   write (store element_value_i at low_index_i and fold it into its block
//   summary), a query (min / max over low_index_i..high_index_i inclusive)
//   or a clear (reset every block summary). Op code 3 is dropped.
//   Output channel (out_valid_o / out_ready_i) carries one item per query:
//   range_minimum_o, range_maximum_o and range_empty_o.
//   Timing: items are handled one at a time. A write folds its summary in
//   ST_WR before the next item is taken; an ignored item keeps the block in
//   ST_IDLE; a clear sweeps one summary entry per cycle. A non-empty query
//   makes R reads along its walk, where R is up to 2*(BLOCK_LEN-1) element
//   reads for the edge blocks plus one summary read per whole block. The
//   walk issues one read per cycle into whichever RAM the current position
//   needs; the RAM read data is registered, and the result goes to the
//   output register after the last read data is folded in. An empty query
//   makes no reads.
//   Reset: a sweep writes the summary RAM to its idle values;
//   in_ready_o stays low until it finishes. The element RAM is not
//   cleared.
//   Stall: a result waits in the output register; the next item is taken
//   while it waits, and a finished query holds only if the register is full.
// ----------------------------------------------------------------------------
module block_range_min_max_query #(
  parameter int unsigned MAX_ELEMENTS = 1024,
  parameter int unsigned BLOCK_LEN    = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [rmq_pkg::OP_W-1:0]         op_i,
  input  logic [rmq_pkg::IDX_W-1:0]        low_index_i,
  input  logic [rmq_pkg::IDX_W-1:0]        high_index_i,
  input  logic signed [rmq_pkg::DATA_W-1:0] element_value_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic signed [rmq_pkg::DATA_W-1:0] range_minimum_o,
  output logic signed [rmq_pkg::DATA_W-1:0] range_maximum_o,
  output logic                             range_empty_o
);

  import rmq_pkg::*;

  localparam int unsigned BLOCK_COUNT = (MAX_ELEMENTS + BLOCK_LEN - 1) / BLOCK_LEN;
  localparam int unsigned LOG_B = $clog2(BLOCK_LEN);
  localparam int unsigned EW    = $clog2(MAX_ELEMENTS);
  localparam int unsigned BW    = (BLOCK_COUNT > 1) ? $clog2(BLOCK_COUNT) : 1;
  localparam int unsigned IW    = $clog2(MAX_ELEMENTS + 1);
  // Walk position: wide enough for every in-range index and for MAX_ELEMENTS.
  localparam int unsigned CW    = (IW > IDX_W) ? IW : IDX_W;
  localparam int unsigned SW    = CW + 1;
  localparam int unsigned SUM_W = 2 * DATA_W;

  localparam logic [1:0] ST_CLR  = 2'd0;
  localparam logic [1:0] ST_IDLE = 2'd1;
  localparam logic [1:0] ST_WR   = 2'd2;
  localparam logic [1:0] ST_QRY  = 2'd3;

  logic [1:0]    state_q, state_d;
  logic [BW-1:0] clr_q, clr_d;
  logic [CW-1:0] pos_q, pos_d;
  logic [CW-1:0] hi_q, hi_d;
  logic          empty_q, empty_d;
  logic          rd_valid_q, rd_valid_d;
  rd_src_e       rd_src_q, rd_src_d;
  logic [BW-1:0] wr_blk_q, wr_blk_d;
  logic signed [DATA_W-1:0] wr_val_q, wr_val_d;
  logic signed [DATA_W-1:0] mn_q, mn_d;
  logic signed [DATA_W-1:0] mx_q, mx_d;

  logic          out_valid_q, out_valid_d;
  logic signed [DATA_W-1:0] out_min_q, out_min_d;
  logic signed [DATA_W-1:0] out_max_q, out_max_d;
  logic          out_empty_q, out_empty_d;

  // RAM ports
  logic              elem_we;
  logic [EW-1:0]     elem_wr_addr, elem_rd_addr;
  logic [DATA_W-1:0] elem_rd_data;
  logic              sum_we;
  logic [BW-1:0]     sum_wr_addr, sum_rd_addr;
  logic [SUM_W-1:0]  sum_wr_data, sum_rd_data;

  logic          in_fire;
  logic [CW-1:0] lo_ext, hi_ext, hi_eff;
  logic          lo_in_range;
  logic [CW-1:0] lo_blk_full, pos_blk_full;
  logic          issue, aligned, whole, finish;
  logic [SW-1:0] block_end, pos_next;
  logic signed [DATA_W-1:0] sum_min, sum_max, cand_min, cand_max;

  rmq_ram #(
    .DEPTH (MAX_ELEMENTS),
    .WIDTH (DATA_W),
    .AW    (EW)
  ) u_elem_ram (
    .clk_i     (clk_i),
    .we_i      (elem_we),
    .wr_addr_i (elem_wr_addr),
    .wr_data_i (element_value_i),
    .rd_addr_i (elem_rd_addr),
    .rd_data_o (elem_rd_data)
  );

  rmq_ram #(
    .DEPTH (BLOCK_COUNT),
    .WIDTH (SUM_W),
    .AW    (BW)
  ) u_sum_ram (
    .clk_i     (clk_i),
    .we_i      (sum_we),
    .wr_addr_i (sum_wr_addr),
    .wr_data_i (sum_wr_data),
    .rd_addr_i (sum_rd_addr),
    .rd_data_o (sum_rd_data)
  );

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;

  // Decode the incoming indices; clamp the query end to the last element.
  assign lo_ext      = CW'(low_index_i);
  assign hi_ext      = CW'(high_index_i);
  assign hi_eff      = (hi_ext > CW'(MAX_ELEMENTS - 1)) ? CW'(MAX_ELEMENTS - 1) : hi_ext;
  assign lo_in_range = (lo_ext < CW'(MAX_ELEMENTS));
  assign lo_blk_full = lo_ext >> LOG_B;
  assign pos_blk_full = pos_q >> LOG_B;

  // Walk step: a block-aligned position whose whole block fits reads the
  // summary and jumps a block; otherwise read one element.
  assign issue     = (state_q == ST_QRY) && (pos_q <= hi_q);
  assign aligned   = (pos_q[LOG_B-1:0] == '0);
  assign block_end = SW'(pos_q) + SW'(BLOCK_LEN - 1);
  assign whole     = aligned && (block_end <= SW'(hi_q));
  assign pos_next  = SW'(pos_q) + (whole ? SW'(BLOCK_LEN) : SW'(1));
  assign finish    = (state_q == ST_QRY) && !issue && !rd_valid_q
                     && (!out_valid_q || out_ready_i);

  assign sum_min  = sum_rd_data[DATA_W-1:0];
  assign sum_max  = sum_rd_data[SUM_W-1:DATA_W];
  assign cand_min = (rd_src_q == SRC_SUMMARY) ? sum_min : elem_rd_data;
  assign cand_max = (rd_src_q == SRC_SUMMARY) ? sum_max : elem_rd_data;

  // RAM addressing
  assign elem_we      = in_fire && (op_i == OP_WRITE) && lo_in_range;
  assign elem_wr_addr = low_index_i[EW-1:0];
  assign elem_rd_addr = pos_q[EW-1:0];
  assign sum_rd_addr  = (state_q == ST_IDLE) ? lo_blk_full[BW-1:0] : pos_blk_full[BW-1:0];

  always_comb begin
    sum_we      = 1'b0;
    sum_wr_addr = clr_q;
    sum_wr_data = {INT_MIN, INT_MAX};
    if (state_q == ST_CLR) begin
      sum_we = 1'b1;
    end else if (state_q == ST_WR) begin
      sum_we      = 1'b1;
      sum_wr_addr = wr_blk_q;
      sum_wr_data = {((wr_val_q > sum_max) ? wr_val_q : sum_max),
                     ((wr_val_q < sum_min) ? wr_val_q : sum_min)};
    end
  end

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    pos_d       = pos_q;
    hi_d        = hi_q;
    empty_d     = empty_q;
    rd_valid_d  = 1'b0;
    rd_src_d    = rd_src_q;
    wr_blk_d    = wr_blk_q;
    wr_val_d    = wr_val_q;
    mn_d        = mn_q;
    mx_d        = mx_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_min_d   = out_min_q;
    out_max_d   = out_max_q;
    out_empty_d = out_empty_q;

    unique case (state_q)
      ST_CLR: begin
        clr_d = clr_q + BW'(1);
        if (clr_q == BW'(BLOCK_COUNT - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          case (op_i)
            OP_WRITE: begin
              // Summary read issued this cycle; fold next cycle.
              wr_blk_d = lo_blk_full[BW-1:0];
              wr_val_d = element_value_i;
              if (lo_in_range) begin
                state_d = ST_WR;
              end
            end
            OP_QUERY: begin
              pos_d   = lo_ext;
              hi_d    = hi_eff;
              empty_d = (lo_ext > hi_eff);
              mn_d    = INT_MAX;
              mx_d    = INT_MIN;
              state_d = ST_QRY;
            end
            OP_CLEAR: begin
              clr_d   = '0;
              state_d = ST_CLR;
            end
            default: begin
              // Drop unknown ops.
            end
          endcase
        end
      end
      ST_WR: begin
        state_d = ST_IDLE;
      end
      ST_QRY: begin
        if (issue) begin
          rd_valid_d = 1'b1;
          rd_src_d   = whole ? SRC_SUMMARY : SRC_ELEMENT;
          pos_d      = pos_next[CW-1:0];
        end
        if (rd_valid_q) begin
          if (cand_min < mn_q) mn_d = cand_min;
          if (cand_max > mx_q) mx_d = cand_max;
        end
        if (finish) begin
          out_valid_d = 1'b1;
          out_min_d   = mn_q;
          out_max_d   = mx_q;
          out_empty_d = empty_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLR;
      clr_q       <= '0;
      rd_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      rd_valid_q  <= rd_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q       <= pos_d;
    hi_q        <= hi_d;
    empty_q     <= empty_d;
    rd_src_q    <= rd_src_d;
    wr_blk_q    <= wr_blk_d;
    wr_val_q    <= wr_val_d;
    mn_q        <= mn_d;
    mx_q        <= mx_d;
    out_min_q   <= out_min_d;
    out_max_q   <= out_max_d;
    out_empty_q <= out_empty_d;
  end

  assign out_valid_o     = out_valid_q;
  assign range_minimum_o = out_min_q;
  assign range_maximum_o = out_max_q;
  assign range_empty_o   = out_empty_q;

  // A new result only comes from the end of a query walk.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q) == ST_QRY)
    else $error("result appeared outside a query");

  // Read data is in flight only while a query walks.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_valid_q |-> state_q == ST_QRY)
    else $error("stray read data outside a query");

  // A non-empty walk never steps more than one past the end of its range.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_QRY) && !empty_q |-> SW'(pos_q) <= SW'(hi_q) + SW'(1))
    else $error("query walk overran its range");

  // An in-range write goes on to fold its block summary.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && (op_i == OP_WRITE) && lo_in_range |=> state_q == ST_WR)
    else $error("write did not update its block summary");

endmodule

// File: dv/block_range_min_max_query_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// block_range_min_max_query_checker
// Watches both channels of the range min / max engine, keeps its own copy of
// the element array and block summaries, and checks every query result.
// ----------------------------------------------------------------------------
module block_range_min_max_query_checker #(
  parameter int unsigned MAX_ELEMENTS = 1024,
  parameter int unsigned BLOCK_LEN    = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  logic                              in_ready_i,
  input  logic [rmq_pkg::OP_W-1:0]          op_i,
  input  logic [rmq_pkg::IDX_W-1:0]         low_index_i,
  input  logic [rmq_pkg::IDX_W-1:0]         high_index_i,
  input  logic signed [rmq_pkg::DATA_W-1:0] element_value_i,
  input  logic                              out_valid_i,
  input  logic                              out_ready_i,
  input  logic signed [rmq_pkg::DATA_W-1:0] range_minimum_i,
  input  logic signed [rmq_pkg::DATA_W-1:0] range_maximum_i,
  input  logic                              range_empty_i,
  output int                                error_count_o,
  output int                                pending_count_o,
  output int                                result_count_o
);

  import rmq_pkg::*;

  localparam int unsigned BLOCK_COUNT = (MAX_ELEMENTS + BLOCK_LEN - 1) / BLOCK_LEN;

  typedef struct {
    logic signed [DATA_W-1:0] minimum;
    logic signed [DATA_W-1:0] maximum;
    logic                     empty;
  } range_result_t;

  logic signed [DATA_W-1:0] element_mem [MAX_ELEMENTS];
  logic signed [DATA_W-1:0] blk_min     [BLOCK_COUNT];
  logic signed [DATA_W-1:0] blk_max     [BLOCK_COUNT];

  range_result_t pending_ranges [$];
  range_result_t oldest_range;
  int            mismatch_total;
  int            checked_total;

  function automatic void clear_summaries();
    for (int unsigned b = 0; b < BLOCK_COUNT; b++) begin
      blk_min[b] = INT_MAX;
      blk_max[b] = INT_MIN;
    end
  endfunction

  function automatic void fold(inout range_result_t r, input logic signed [DATA_W-1:0] lo_v,
                               input logic signed [DATA_W-1:0] hi_v);
    if (lo_v < r.minimum) r.minimum = lo_v;
    if (hi_v > r.maximum) r.maximum = hi_v;
  endfunction

  // Walk edge blocks by element and whole blocks by summary.
  function automatic range_result_t predict_range(int unsigned lo, int unsigned hi);
    range_result_t r;
    int unsigned   i;
    r.minimum = INT_MAX;
    r.maximum = INT_MIN;
    r.empty   = 1'b0;
    if (hi >= MAX_ELEMENTS) hi = MAX_ELEMENTS - 1;
    if (lo > hi) begin
      r.empty = 1'b1;
      return r;
    end
    i = lo;
    while (i <= hi && (i % BLOCK_LEN) != 0) begin
      fold(r, element_mem[i], element_mem[i]);
      i++;
    end
    while (i + BLOCK_LEN - 1 <= hi) begin
      fold(r, blk_min[i / BLOCK_LEN], blk_max[i / BLOCK_LEN]);
      i += BLOCK_LEN;
    end
    while (i <= hi) begin
      fold(r, element_mem[i], element_mem[i]);
      i++;
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    int unsigned idx;
    if (!rst_ni) begin
      for (int unsigned k = 0; k < MAX_ELEMENTS; k++) element_mem[k] = '0;
      clear_summaries();
      pending_ranges.delete();
      mismatch_total = 0;
      checked_total  = 0;
    end else begin
      // Check the result first: a query taken at this edge cannot finish here.
      if (out_valid_i && out_ready_i) begin
        if (pending_ranges.size() == 0) begin
          $display("%0t: unexpected result, expected none, got min %0d max %0d empty %0b",
                   $time, range_minimum_i, range_maximum_i, range_empty_i);
          mismatch_total++;
        end else begin
          oldest_range = pending_ranges.pop_front();
          checked_total++;
          if (range_minimum_i !== oldest_range.minimum) begin
            $display("%0t: range_minimum mismatch, expected %0d, got %0d",
                     $time, oldest_range.minimum, range_minimum_i);
            mismatch_total++;
          end
          if (range_maximum_i !== oldest_range.maximum) begin
            $display("%0t: range_maximum mismatch, expected %0d, got %0d",
                     $time, oldest_range.maximum, range_maximum_i);
            mismatch_total++;
          end
          if (range_empty_i !== oldest_range.empty) begin
            $display("%0t: range_empty mismatch, expected %0b, got %0b",
                     $time, oldest_range.empty, range_empty_i);
            mismatch_total++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        case (op_i)
          OP_WRITE: begin
            idx = low_index_i;
            if (idx < MAX_ELEMENTS) begin
              element_mem[idx] = element_value_i;
              if (element_value_i < blk_min[idx / BLOCK_LEN])
                blk_min[idx / BLOCK_LEN] = element_value_i;
              if (element_value_i > blk_max[idx / BLOCK_LEN])
                blk_max[idx / BLOCK_LEN] = element_value_i;
            end
          end
          OP_QUERY: pending_ranges.push_back(predict_range(low_index_i, high_index_i));
          OP_CLEAR: clear_summaries();
          default: ;
        endcase
      end
    end
    error_count_o   <= mismatch_total;
    pending_count_o <= pending_ranges.size();
    result_count_o  <= checked_total;
  end

endmodule

// File: dv/block_range_min_max_query_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// block_range_min_max_query_tb
// Drives writes, queries, clears and dropped ops into the range min / max
// engine with random gaps and output stalls; a checker beside the block
// predicts and compares every result.
// ----------------------------------------------------------------------------
module block_range_min_max_query_tb;
  import rmq_pkg::*;

  localparam int unsigned MAX_ELEMENTS = 1024;
  localparam int unsigned BLOCK_LEN    = 32;
  localparam int unsigned BLOCK_COUNT  = MAX_ELEMENTS / BLOCK_LEN;
  localparam int unsigned RANDOM_ITEMS = 1700;
  localparam int unsigned DRAIN_CYCLES = 200;
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;

  // Op code 3 has no meaning; the block must drop it.
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     in_valid_i;
  logic                     in_ready_o;
  logic [OP_W-1:0]          op_i;
  logic [IDX_W-1:0]         low_index_i;
  logic [IDX_W-1:0]         high_index_i;
  logic signed [DATA_W-1:0] element_value_i;
  logic                     out_valid_o;
  logic                     out_ready_i;
  logic signed [DATA_W-1:0] range_minimum_o;
  logic signed [DATA_W-1:0] range_maximum_o;
  logic                     range_empty_o;

  int error_count;
  int pending_count;
  int result_count;

  // Longest gap before each input item and longest stall before each result.
  int unsigned gap_max;
  int unsigned stall_max;

  // Indices written since reset; a clear keeps the elements, so never drop.
  bit written [MAX_ELEMENTS];

  int unsigned writes_sent;
  int unsigned queries_sent;
  int unsigned empties_sent;
  int unsigned clears_sent;
  int unsigned dropped_sent;
  int unsigned cycle_count;

  block_range_min_max_query #(
    .MAX_ELEMENTS(MAX_ELEMENTS),
    .BLOCK_LEN   (BLOCK_LEN)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .op_i           (op_i),
    .low_index_i    (low_index_i),
    .high_index_i   (high_index_i),
    .element_value_i(element_value_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .range_minimum_o(range_minimum_o),
    .range_maximum_o(range_maximum_o),
    .range_empty_o  (range_empty_o)
  );

  block_range_min_max_query_checker #(
    .MAX_ELEMENTS(MAX_ELEMENTS),
    .BLOCK_LEN   (BLOCK_LEN)
  ) i_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .op_i           (op_i),
    .low_index_i    (low_index_i),
    .high_index_i   (high_index_i),
    .element_value_i(element_value_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .range_minimum_i(range_minimum_o),
    .range_maximum_i(range_maximum_o),
    .range_empty_i  (range_empty_o),
    .error_count_o  (error_count),
    .pending_count_o(pending_count),
    .result_count_o (result_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Stop a hung run; the limit is several times the slowest legal run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still expected",
               cycle_count, pending_count);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // True when every element the query reads one by one (the partial edge
  // blocks) has been written; whole blocks are read through their summaries.
  function automatic bit walk_ok(int unsigned lo, int unsigned hi);
    int unsigned i;
    if (lo > hi) return 1'b1;
    i = lo;
    while (i <= hi && (i % BLOCK_LEN) != 0) begin
      if (!written[i]) return 1'b0;
      i++;
    end
    while (i + BLOCK_LEN - 1 <= hi) i += BLOCK_LEN;
    while (i <= hi) begin
      if (!written[i]) return 1'b0;
      i++;
    end
    return 1'b1;
  endfunction

  // Favor the signed extremes and values near zero, where compare bugs show.
  function automatic logic signed [DATA_W-1:0] pick_value();
    logic signed [DATA_W-1:0] v;
    case ($urandom_range(9, 0))
      0: v = INT_MIN;
      1: v = INT_MAX;
      2: begin
        v = $urandom_range(200, 0);
        v = v - 100;
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // Build a legal query: empty, narrow, wide, block-aligned or not. Fall back
  // to a whole-block range when no random try passes the written check.
  function automatic void pick_query(output int unsigned lo, output int unsigned hi);
    int unsigned kind;
    int unsigned a;
    int unsigned b;
    int unsigned t;
    kind = $urandom_range(99, 0);
    if (kind < 8) begin
      hi = $urandom_range(MAX_ELEMENTS - 2, 0);
      lo = $urandom_range(MAX_ELEMENTS - 1, hi + 1);
      return;
    end
    for (int tries = 0; tries < 24; tries++) begin
      a = $urandom_range(MAX_ELEMENTS - 1, 0);
      if (kind < 35) begin
        b = a + $urandom_range(2 * BLOCK_LEN, 0);
        if (b > MAX_ELEMENTS - 1) b = MAX_ELEMENTS - 1;
      end else begin
        b = $urandom_range(MAX_ELEMENTS - 1, 0);
      end
      if (a > b) begin
        t = a;
        a = b;
        b = t;
      end
      if ($urandom_range(1, 0)) a = a - (a % BLOCK_LEN);
      if ($urandom_range(1, 0)) b = b | (BLOCK_LEN - 1);
      if (walk_ok(a, b)) begin
        lo = a;
        hi = b;
        return;
      end
    end
    a = $urandom_range(BLOCK_COUNT - 1, 0);
    b = $urandom_range(BLOCK_COUNT - 1, 0);
    if (a > b) begin
      t = a;
      a = b;
      b = t;
    end
    lo = a * BLOCK_LEN;
    hi = b * BLOCK_LEN + BLOCK_LEN - 1;
  endfunction

  // Offer one item after a random gap and hold it until the block takes it.
  task automatic send_item(input logic [OP_W-1:0] op, input int unsigned lo,
                           input int unsigned hi, input logic signed [DATA_W-1:0] value);
    int unsigned gap;
    gap = $urandom_range(gap_max, 0);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    op_i            <= op;
    low_index_i     <= IDX_W'(lo);
    high_index_i    <= IDX_W'(hi);
    element_value_i <= value;
    do @(posedge clk_i); while (!in_ready_o);
    case (op)
      OP_WRITE: begin
        written[lo] = 1'b1;
        writes_sent++;
      end
      OP_QUERY: begin
        queries_sent++;
        if (lo > hi) empties_sent++;
      end
      OP_CLEAR: clears_sent++;
      default:  dropped_sent++;
    endcase
  endtask

  // Result side: draw a stall per result, hold ready low through it, then
  // take the result; with no stall keep ready high across results.
  initial begin : result_sink
    int unsigned stall;
    out_ready_i = 1'b0;
    while (rst_ni !== 1'b1) @(posedge clk_i);
    forever begin
      stall = $urandom_range(stall_max, 0);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        do @(posedge clk_i); while (!out_valid_o);
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  initial begin : stimulus
    int unsigned lo;
    int unsigned hi;
    int unsigned pick;
    int unsigned fill_ptr;
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    op_i            = OP_WRITE;
    low_index_i     = '0;
    high_index_i    = '0;
    element_value_i = '0;
    writes_sent     = 0;
    queries_sent    = 0;
    empties_sent    = 0;
    clears_sent     = 0;
    dropped_sent    = 0;
    fill_ptr        = 0;
    gap_max         = 2;
    stall_max       = 2;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: fresh summaries, empty ranges and a dropped op first.
    send_item(OP_QUERY, 0, MAX_ELEMENTS - 1, 0);
    send_item(OP_QUERY, MAX_ELEMENTS - 1, 0, -1);
    send_item(OP_QUERY, 512, 511, 0);
    send_item(OP_UNUSED, MAX_ELEMENTS - 1, MAX_ELEMENTS - 1, INT_MIN);
    // Extremes at both array ends and on a block boundary.
    send_item(OP_WRITE, 0, MAX_ELEMENTS - 1, INT_MIN);
    send_item(OP_WRITE, 1, 0, INT_MAX);
    send_item(OP_WRITE, BLOCK_LEN - 1, 0, 5);
    send_item(OP_WRITE, BLOCK_LEN, 0, 7);
    send_item(OP_WRITE, MAX_ELEMENTS - 2, 0, 0);
    send_item(OP_WRITE, MAX_ELEMENTS - 1, MAX_ELEMENTS - 1, -1);
    send_item(OP_QUERY, 0, 1, 0);
    send_item(OP_QUERY, 1, 1, 0);
    send_item(OP_QUERY, BLOCK_LEN - 1, BLOCK_LEN, 0);
    send_item(OP_QUERY, 0, BLOCK_LEN - 1, 0);
    send_item(OP_QUERY, 0, MAX_ELEMENTS - 1, 0);
    send_item(OP_QUERY, MAX_ELEMENTS - 2, MAX_ELEMENTS - 1, 0);
    send_item(OP_QUERY, MAX_ELEMENTS - 1, MAX_ELEMENTS - 1, 0);
    send_item(OP_QUERY, BLOCK_LEN, MAX_ELEMENTS - 1, 0);
    // Rewrite: the element takes the new value, the summary keeps the old.
    send_item(OP_WRITE, 0, 0, 100);
    send_item(OP_QUERY, 0, 0, 0);
    send_item(OP_QUERY, 0, BLOCK_LEN - 1, 0);
    // Clear resets the summaries but keeps the elements.
    send_item(OP_CLEAR, 0, 0, 0);
    send_item(OP_QUERY, 0, MAX_ELEMENTS - 1, 0);
    send_item(OP_QUERY, 0, 1, 0);

    // Random: mostly fill-then-query traffic, some clears and dropped ops.
    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      // Change the idle profile every 200 items, including no idling at all.
      if (n % 200 == 0) begin
        case ($urandom_range(4, 0))
          0: begin gap_max = 0; stall_max = 0; end
          1: begin gap_max = 7; stall_max = 7; end
          2: begin gap_max = 0; stall_max = 7; end
          3: begin gap_max = 7; stall_max = 0; end
          default: begin gap_max = 3; stall_max = 3; end
        endcase
      end
      pick = $urandom_range(99, 0);
      if (pick < 46) begin
        if ($urandom_range(9, 0) < 6) begin
          lo       = fill_ptr;
          fill_ptr = (fill_ptr + 1) % MAX_ELEMENTS;
        end else begin
          lo = $urandom_range(MAX_ELEMENTS - 1, 0);
        end
        send_item(OP_WRITE, lo, $urandom_range(MAX_ELEMENTS - 1, 0), pick_value());
      end else if (pick < 88) begin
        pick_query(lo, hi);
        send_item(OP_QUERY, lo, hi, $urandom);
      end else if (pick < 94) begin
        send_item(OP_CLEAR, $urandom_range(MAX_ELEMENTS - 1, 0),
                  $urandom_range(MAX_ELEMENTS - 1, 0), $urandom);
      end else begin
        send_item(OP_UNUSED, $urandom_range(MAX_ELEMENTS - 1, 0),
                  $urandom_range(MAX_ELEMENTS - 1, 0), $urandom);
      end
    end
    in_valid_i <= 1'b0;

    // Drain: wait for every expected result, then watch for strays.
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Covered %0d writes, %0d queries (%0d empty), %0d clears, %0d dropped ops",
             writes_sent, queries_sent, empties_sent, clears_sent, dropped_sent);
    $display("Checked %0d results, %0d mismatches, in %0d cycles",
             result_count, error_count, cycle_count);
    if (error_count == 0 && pending_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: block_range_min_max_query.f
hdl/rmq_pkg.sv
hdl/rmq_ram.sv
hdl/block_range_min_max_query.sv
dv/block_range_min_max_query_checker.sv
dv/block_range_min_max_query_tb.sv
